// ===== rtl/kwe_pkg.sv =====
// kwe_pkg: shared types, constants and symbol lookup for kmer_word_encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package kwe_pkg;

   localparam int MAX_WORD = 32;
   localparam int CNT_W    = $clog2(MAX_WORD + 1);
   localparam int SIZE_W   = 6;
   localparam int MODE_W   = 2;
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 64;
   localparam int DIGIT_W  = 5;
   localparam int CSR_W    = 6;

   // alphabet modes; the unused code falls back to nucleotide
   localparam logic [MODE_W-1:0] MODE_NUC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_P23 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_P21 = 2'd2;

   // configuration register indexes
   localparam logic REG_ALPHABET_MODE = 1'b0;
   localparam logic REG_WORD_SIZE     = 1'b1;

   localparam logic [SIZE_W-1:0] WORD_SIZE_RESET = 6'd2;
   localparam logic [SIZE_W-1:0] MAX_WORD_SIZE   = SIZE_W'(MAX_WORD);

   localparam logic [SYM_W-1:0] CHAR_A = 8'h41;
   localparam logic [SYM_W-1:0] CHAR_C = 8'h43;
   localparam logic [SYM_W-1:0] CHAR_G = 8'h47;
   localparam logic [SYM_W-1:0] CHAR_T = 8'h54;
   localparam logic [SYM_W-1:0] CHAR_Z = 8'h5A;

   localparam logic [7:0] NO_DIGIT = 8'hFF;

   localparam logic [7:0] TAB23 [26] = '{
      8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, NO_DIGIT, 8'd9, 8'd10,
      8'd11, 8'd12, NO_DIGIT, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19,
      8'd20, NO_DIGIT, 8'd21, 8'd22
   };
   localparam logic [7:0] TAB21 [26] = '{
      8'd0, NO_DIGIT, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, NO_DIGIT, 8'd8, 8'd9,
      8'd10, 8'd11, NO_DIGIT, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18,
      8'd19, NO_DIGIT, 8'd20, NO_DIGIT
   };

   typedef struct packed {
      logic               ok;
      logic [DIGIT_W-1:0] digit;
   } sym_map_type;

   typedef struct packed {
      logic               restart;
      logic               ok;
      logic [DIGIT_W-1:0] digit;
   } sym_info_type;

   function automatic sym_map_type map_symbol(input logic [MODE_W-1:0] mode,
                                              input logic [SYM_W-1:0] symbol);
      sym_map_type     res;
      logic [SYM_W-1:0] off;
      logic [7:0]       entry;
      res   = '0;
      off   = symbol - CHAR_A;
      entry = NO_DIGIT;
      case (mode)
         MODE_P23, MODE_P21: begin
            if (symbol >= CHAR_A && symbol <= CHAR_Z) begin
               entry = (mode == MODE_P23) ? TAB23[off[4:0]] : TAB21[off[4:0]];
            end
            if (entry != NO_DIGIT) begin
               res.ok    = 1'b1;
               res.digit = entry[DIGIT_W-1:0];
            end
         end
         default: begin
            case (symbol)
               CHAR_A:  res = '{ok: 1'b1, digit: DIGIT_W'(0)};
               CHAR_C:  res = '{ok: 1'b1, digit: DIGIT_W'(1)};
               CHAR_G:  res = '{ok: 1'b1, digit: DIGIT_W'(2)};
               CHAR_T:  res = '{ok: 1'b1, digit: DIGIT_W'(3)};
               default: res = '0;
            endcase
         end
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/kmer_word_encoder.sv =====
// kmer_word_encoder: top level; configuration registers and the two stages.
// Depends on kwe_pkg, kwe_in_stage and kwe_accum.
//
// Packs a stream of sequence characters into integer words of word_size
// characters (2 bits each for ACGT, base 23 or base 21 digits for protein).
// req channel: one character per transfer, tdata = symbol, tuser = restart.
// rsp channel: one transfer per finished word, tdata = code,
// tuser = invalid (code is then zero).
// csr port: csr_addr 0 = alphabet_mode, 1 = word_size; write while idle.
// An accepted character is held in the input register and then folded into
// the word; a word it completes enters the result register at that fold.
// Throughput: one character per cycle while rsp does not stall; the
// multiply-add into the 64-bit accumulator register is combinational.
// Reset clears the partial word and the result valid flag and restores
// alphabet_mode 0 and word_size 2. When rsp stalls, the result holds and
// one more character is buffered in the input register before req_tready
// drops.
`timescale 1ns / 1ps
module kmer_word_encoder
   import kwe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [SYM_W-1:0]   req_tdata,   // [7:0] symbol
   input  logic               req_tuser,   // [0] restart
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [CODE_W-1:0]  rsp_tdata,   // [63:0] code
   output logic               rsp_tuser,   // [0] invalid
   input  logic               csr_we,
   input  logic               csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] eff_size;
   logic              info_valid, advance;
   sym_info_type      info;

   always_comb begin
      mode_in = mode_ff;
      size_in = size_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_ALPHABET_MODE: mode_in = csr_wdata[MODE_W-1:0];
            REG_WORD_SIZE:     size_in = csr_wdata[SIZE_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NUC;
         size_ff <= WORD_SIZE_RESET;
      end else begin
         mode_ff <= mode_in;
         size_ff <= size_in;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (size_ff > MAX_WORD_SIZE) begin
         eff_size = MAX_WORD_SIZE;
      end else begin
         eff_size = size_ff;
      end
   end

   kwe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .mode       (mode_ff),
      .advance    (advance),
      .info_valid (info_valid),
      .info       (info)
   );

   kwe_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .eff_size   (eff_size),
      .info_valid (info_valid),
      .info       (info),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/kwe_in_stage.sv =====
// kwe_in_stage: input register of kmer_word_encoder and symbol-to-digit lookup.
// Depends on kwe_pkg.
`timescale 1ns / 1ps
module kwe_in_stage
   import kwe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [SYM_W-1:0]   req_tdata,
   input  logic               req_tuser,
   input  logic [MODE_W-1:0]  mode,
   input  logic               advance,
   output logic               info_valid,
   output sym_info_type       info
);

   logic             valid_ff, valid_in;
   logic [SYM_W-1:0] symbol_ff, symbol_in;
   logic             restart_ff, restart_in;
   logic             take;
   sym_map_type      map;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in   = valid_ff;
      symbol_in  = symbol_ff;
      restart_in = restart_ff;
      if (take) begin
         valid_in   = 1'b1;
         symbol_in  = req_tdata;
         restart_in = req_tuser;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      symbol_ff  <= symbol_in;
      restart_ff <= restart_in;
   end

   assign map        = map_symbol(mode, symbol_ff);
   assign info_valid = valid_ff;
   assign info       = '{restart: restart_ff, ok: map.ok, digit: map.digit};

endmodule

// ===== rtl/kwe_accum.sv =====
// kwe_accum: word accumulator, character count and result register.
// Depends on kwe_pkg.
`timescale 1ns / 1ps
module kwe_accum
   import kwe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [MODE_W-1:0]  mode,
   input  logic [SIZE_W-1:0]  eff_size,
   input  logic               info_valid,
   input  sym_info_type       info,
   output logic               advance,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [CODE_W-1:0]  rsp_tdata,
   output logic               rsp_tuser
);

   logic [CODE_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              bad_ff, bad_in;
   logic              out_valid_ff, out_valid_in;
   logic [CODE_W-1:0] out_code_ff, out_code_in;
   logic              out_bad_ff, out_bad_in;
   logic [CODE_W-1:0] acc_base, acc_next, digit_ext;
   logic [CNT_W-1:0]  cnt_next;
   logic              bad_next, done;

   assign advance   = info_valid && (!out_valid_ff || rsp_tready);
   assign digit_ext = CODE_W'(info.digit);

   always_comb begin
      acc_base = info.restart ? '0 : acc_ff;
      case (mode)
         MODE_P23: acc_next = (acc_base << 4) + (acc_base << 2) + (acc_base << 1)
                              + acc_base + digit_ext;
         MODE_P21: acc_next = (acc_base << 4) + (acc_base << 2) + acc_base + digit_ext;
         default:  acc_next = (acc_base << 2) | digit_ext;
      endcase
      cnt_next = (info.restart ? '0 : cnt_ff) + CNT_W'(1);
      bad_next = (info.restart ? 1'b0 : bad_ff) | !info.ok;
      done     = cnt_next >= CNT_W'(eff_size);
   end

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      bad_in       = bad_ff;
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_bad_in   = out_bad_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         if (done) begin
            acc_in       = '0;
            cnt_in       = '0;
            bad_in       = 1'b0;
            out_valid_in = 1'b1;
            out_code_in  = bad_next ? '0 : acc_next;
            out_bad_in   = bad_next;
         end else begin
            acc_in = acc_next;
            cnt_in = cnt_next;
            bad_in = bad_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         bad_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         bad_ff       <= bad_in;
         out_valid_ff <= out_valid_in;
      end
      out_code_ff <= out_code_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_code_ff;
   assign rsp_tuser  = out_bad_ff;

endmodule

// ===== rtl/kwe_checker.sv =====
// kwe_checker: port-level assertions for kmer_word_encoder, bound to the top.
// Depends on kwe_pkg and kmer_word_encoder.
`timescale 1ns / 1ps
module kwe_checker
   import kwe_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [CODE_W-1:0]  rsp_tdata,
   input logic               rsp_tuser
);

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("invalid word with nonzero code");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a stalled result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind kmer_word_encoder kwe_checker u_kwe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
